FILE: sv/tmse_pkg.sv
package tmse_pkg;

  // Fixed geometry of the machine
  localparam int STATE_COUNT   = 32;
  localparam int TAPE_CELLS    = 4096;
  localparam int OPS_PER_RULE  = 4;
  localparam int STATE_W       = 5;
  localparam int SYM_W         = 8;
  localparam int POS_W         = 12;
  localparam int OPS_W         = 40;
  localparam int SLOT_W        = 10;
  localparam int STEP_W        = 32;
  localparam int TAPE_AW       = $clog2(TAPE_CELLS);
  localparam int RULE_AW       = STATE_W + SYM_W;
  localparam int RULE_DEPTH    = STATE_COUNT * (2 ** SYM_W);
  localparam int SLOT_IDX_W    = (OPS_PER_RULE > 1) ? $clog2(OPS_PER_RULE) : 1;
  localparam int BODY_W        = OPS_W + STATE_W;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  localparam logic [SYM_W-1:0]  SYM_BLANK      = 8'd126;
  localparam logic [SYM_W-1:0]  SYM_ANY        = 8'd42;
  localparam logic [STEP_W-1:0] MAX_STEPS_RST  = 32'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS   = 1'b1;

  typedef enum logic [1:0] {
    OP_RULE_WR = 2'd0,
    OP_CELL_WR = 2'd1,
    OP_STEP    = 2'd2,
    OP_CELL_RD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_STEPPED = 3'd1,
    ST_NO_RULE = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_CLAMPED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_LEFT  = 2'd1,
    K_RIGHT = 2'd2,
    K_PRINT = 2'd3
  } kind_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    clr_wr;
    logic    ld_item;
    logic    rule_wr;
    logic    cell_wr;
    logic    trd_head;
    logic    trd_cell;
    logic    rrd_sym;
    logic    rrd_any;
    logic    body_ld;
    logic    op_apply;
    logic    commit;
    logic    st_set;
    status_t st_code;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    op_t  op;
    logic limit_hit;
    logic rule_hit;
    logic op_last;
  } sts_t;

endpackage

FILE: sv/turing_machine_step_engine_core.sv
// Sequencing: a step reads the head cell, then the rule for that symbol, then the wildcard rule
// on a miss, then applies one op per cycle; limit and no-rule steps end without applying ops.
// Throughput: one request at a time; next request accepted the cycle after the strobe.
// Reset: synchronous active low; a clearing pass blanks the tape and empties
// the rule table, busy high meanwhile, config writes taken; the receiver cannot stall.
module turing_machine_step_engine_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_operation,
  input  logic [4:0]                      in_rule_state,
  input  logic [7:0]                      in_rule_symbol,
  input  logic [39:0]                     in_rule_ops,
  input  logic [4:0]                      in_rule_next,
  input  logic signed [11:0]              in_cell_index,
  input  logic [7:0]                      in_cell_value,
  input  logic                            cfg_we,
  input  logic [tmse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            out_valid,
  output logic [2:0]                      out_status,
  output logic [4:0]                      out_state_now,
  output logic signed [11:0]              out_head_pos,
  output logic [7:0]                      out_read_value,
  output logic [31:0]                     out_steps_done
);
  import tmse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tmse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmse_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_operation   (in_operation),
    .in_rule_state  (in_rule_state),
    .in_rule_symbol (in_rule_symbol),
    .in_rule_ops    (in_rule_ops),
    .in_rule_next   (in_rule_next),
    .in_cell_index  (in_cell_index),
    .in_cell_value  (in_cell_value),
    .out_status     (out_status),
    .out_state_now  (out_state_now),
    .out_head_pos   (out_head_pos),
    .out_read_value (out_read_value),
    .out_steps_done (out_steps_done)
  );

endmodule

FILE: sv/tmse_datapath.sv
module tmse_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tmse_pkg::cmd_t                      cmd,
  output tmse_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [tmse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmse_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [1:0]                          in_operation,
  input  logic [4:0]                          in_rule_state,
  input  logic [7:0]                          in_rule_symbol,
  input  logic [39:0]                         in_rule_ops,
  input  logic [4:0]                          in_rule_next,
  input  logic signed [11:0]                  in_cell_index,
  input  logic [7:0]                          in_cell_value,
  output logic [2:0]                          out_status,
  output logic [4:0]                          out_state_now,
  output logic signed [11:0]                  out_head_pos,
  output logic [7:0]                          out_read_value,
  output logic [31:0]                         out_steps_done
);
  import tmse_pkg::*;

  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

  logic [BODY_W:0]          rule_mem [RULE_DEPTH];
  logic [SYM_W-1:0]         tape_mem [TAPE_CELLS];

  logic [RULE_AW-1:0]       clr_cnt_r;
  logic [STEP_W-1:0]        max_steps_r;
  logic [STATE_W-1:0]       cur_state_r, cur_state_nxt;
  logic signed [POS_W-1:0]  head_r, head_nxt;
  logic [STEP_W-1:0]        count_r;
  status_t                  status_r;
  logic                     clamp_r, clamp_nxt;
  logic [SLOT_IDX_W-1:0]    slot_r;
  logic [BODY_W-1:0]        body_r;
  logic [BODY_W:0]          rule_q;
  logic [SYM_W-1:0]         tape_q;

  op_t                      op_r;
  logic [STATE_W-1:0]       rs_r, rn_r;
  logic [SYM_W-1:0]         rsym_r, cval_r;
  logic [OPS_W-1:0]         rops_r;
  logic signed [POS_W-1:0]  cidx_r;

  logic [SLOT_W-1:0]        slot_op;
  kind_t                    slot_kind;
  logic [SYM_W-1:0]         slot_sym;

  logic                     tape_we;
  logic [TAPE_AW-1:0]       tape_waddr, tape_raddr;
  logic [SYM_W-1:0]         tape_wdata;
  logic                     rule_we;
  logic [RULE_AW-1:0]       rule_waddr, rule_raddr;
  logic [BODY_W:0]          rule_wdata;

  // Pick the active op slot
  assign slot_op   = body_r[SLOT_W*slot_r +: SLOT_W];
  assign slot_kind = kind_t'(slot_op[1:0]);
  assign slot_sym  = slot_op[SLOT_W-1:2];

  // Apply one op to the head and track clamping
  always_comb begin
    head_nxt  = head_r;
    clamp_nxt = clamp_r;
    if (cmd.op_apply) begin
      case (slot_kind)
        K_LEFT: begin
          if (head_r != POS_MIN) head_nxt = head_r - 12'sd1;
          else clamp_nxt = 1'b1;
        end
        K_RIGHT: begin
          if (head_r != POS_MAX) head_nxt = head_r + 12'sd1;
          else clamp_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_state_nxt = cur_state_r;
    if (cfg_we && cfg_index == CFG_START_STATE) cur_state_nxt = cfg_wdata[STATE_W-1:0];
    else if (cmd.commit) cur_state_nxt = body_r[BODY_W-1:OPS_W];
  end

  // Tape port muxing: clear sweep, cell write or print
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = {~head_r[POS_W-1], head_r[POS_W-2:0]};
    tape_wdata = slot_sym;
    if (cmd.clr_wr) begin
      tape_we    = 1'b1;
      tape_waddr = clr_cnt_r[TAPE_AW-1:0];
      tape_wdata = SYM_BLANK;
    end else if (cmd.cell_wr) begin
      tape_we    = 1'b1;
      tape_waddr = {~cidx_r[POS_W-1], cidx_r[POS_W-2:0]};
      tape_wdata = cval_r;
    end else if (cmd.op_apply && slot_kind == K_PRINT) begin
      tape_we = 1'b1;
    end
    if (cmd.trd_cell) tape_raddr = {~cidx_r[POS_W-1], cidx_r[POS_W-2:0]};
    else tape_raddr = {~head_r[POS_W-1], head_r[POS_W-2:0]};
  end

  always_comb begin
    rule_we    = cmd.clr_wr | cmd.rule_wr;
    rule_waddr = cmd.clr_wr ? clr_cnt_r : {rs_r, rsym_r};
    rule_wdata = cmd.clr_wr ? '0 : {1'b1, rn_r, rops_r};
    rule_raddr = {cur_state_r, (cmd.rrd_any ? SYM_ANY : tape_q)};
  end

  // Memories
  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
    if (cmd.trd_head || cmd.trd_cell) tape_q <= tape_mem[tape_raddr];
  end

  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[rule_waddr] <= rule_wdata;
    if (cmd.rrd_sym || cmd.rrd_any) rule_q <= rule_mem[rule_raddr];
  end

  // Hold the request fields
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      op_r   <= op_t'(in_operation);
      rs_r   <= in_rule_state;
      rsym_r <= in_rule_symbol;
      rops_r <= in_rule_ops;
      rn_r   <= in_rule_next;
      cidx_r <= in_cell_index;
      cval_r <= in_cell_value;
    end
    if (cmd.body_ld) body_r <= rule_q[BODY_W-1:0];
  end

  // Machine state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r     <= '0;
      max_steps_r   <= MAX_STEPS_RST;
      cur_state_r   <= '0;
      head_r        <= '0;
      count_r       <= '0;
      status_r      <= ST_DONE;
      clamp_r       <= 1'b0;
      slot_r        <= '0;
    end else begin
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_we && cfg_index == CFG_MAX_STEPS) max_steps_r <= cfg_wdata;
      cur_state_r <= cur_state_nxt;
      head_r      <= head_nxt;
      if (cmd.ld_item) begin
        clamp_r  <= 1'b0;
        slot_r   <= '0;
        status_r <= ST_DONE;
      end else begin
        clamp_r <= clamp_nxt;
        if (cmd.op_apply) slot_r <= slot_r + 1'b1;
        if (cmd.st_set) status_r <= cmd.st_code;
        if (cmd.commit) status_r <= clamp_nxt ? ST_CLAMPED : ST_STEPPED;
      end
      if (cmd.commit) count_r <= count_r + 1'b1;
    end
  end

  assign sts.clr_last  = (clr_cnt_r == RULE_AW'(RULE_DEPTH - 1));
  assign sts.op        = op_r;
  assign sts.limit_hit = (count_r >= max_steps_r);
  assign sts.rule_hit  = rule_q[BODY_W];
  assign sts.op_last   = (slot_r == SLOT_IDX_W'(OPS_PER_RULE - 1));

  assign out_status     = status_r;
  assign out_state_now  = cur_state_r;
  assign out_head_pos   = head_r;
  assign out_read_value = tape_q;
  assign out_steps_done = count_r;

endmodule

FILE: sv/tmse_ctrl.sv
module tmse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  input  tmse_pkg::sts_t sts,
  output tmse_pkg::cmd_t cmd
);
  import tmse_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SYM, S_RCHK1, S_RCHK2, S_OPS, S_HRD, S_WAIT
  } state_t;

  state_t state_r, state_nxt;

  // Sequence the request through the datapath
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st_code = ST_DONE;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_RULE_WR: begin
            cmd.rule_wr = 1'b1;
            state_nxt   = S_HRD;
          end
          OP_CELL_WR: begin
            cmd.cell_wr = 1'b1;
            state_nxt   = S_HRD;
          end
          OP_CELL_RD: begin
            cmd.trd_cell = 1'b1;
            state_nxt    = S_WAIT;
          end
          default: begin
            if (sts.limit_hit) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_LIMIT;
              state_nxt   = S_HRD;
            end else begin
              cmd.trd_head = 1'b1;
              state_nxt    = S_SYM;
            end
          end
        endcase
      end
      S_SYM: begin
        cmd.rrd_sym = 1'b1;
        state_nxt   = S_RCHK1;
      end
      S_RCHK1: begin
        if (sts.rule_hit) begin
          cmd.body_ld = 1'b1;
          state_nxt   = S_OPS;
        end else begin
          cmd.rrd_any = 1'b1;
          state_nxt   = S_RCHK2;
        end
      end
      S_RCHK2: begin
        if (sts.rule_hit) begin
          cmd.body_ld = 1'b1;
          state_nxt   = S_OPS;
        end else begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_NO_RULE;
          state_nxt   = S_HRD;
        end
      end
      S_OPS: begin
        cmd.op_apply = 1'b1;
        if (sts.op_last) begin
          cmd.commit = 1'b1;
          state_nxt  = S_HRD;
        end
      end
      S_HRD: begin
        cmd.trd_head = 1'b1;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_WAIT);

`ifndef SYNTHESIS
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_no_dual_rule: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rule_wr && cmd.clr_wr)) else $error("rule write during clear");
`endif

endmodule
